/* src/aldel_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Array list delete engine package
// Shared sizes, command and status codes, and controller/datapath interface
// types for the array list delete engine.
// ----------------------------------------------------------------------------
package aldel_pkg;

   // Number of entries held by the list.
   localparam int CAPACITY = 32;
   // Index into the entry store and width of the entry count.
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int DATA_W = 32;
   localparam int CMD_W = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W = 6;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND    = 2'd0,
      CMD_DEL_FIRST = 2'd1,
      CMD_DEL_LAST  = 2'd2,
      CMD_DEL_VALUE = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // Update applied to the store when a command completes.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_APPEND,
      OP_DEL_HEAD,
      OP_DEL_LAST,
      OP_DEL_MATCH
   } op_type;

   typedef enum logic {
      S_IDLE,
      S_COMMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       commit;
      op_type     op;
      status_type status;
   } ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;
      logic full;
      logic found;
   } stat_type;

endpackage

/* src/array_list_delete_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Array list delete engine
// Packed ordered list of signed 32-bit words with append, delete first,
// delete last and delete by value.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. The accepting edge
// registers the compare of the value against all live entries; in S_COMMIT
// the store update is applied and the result is loaded. The result then sits
// on the rsp_ ports for exactly one cycle with rsp_strobe high; the receiver
// cannot stall it, so it must take each transfer when it appears. A new command
// may be started in that same cycle; none is taken while busy is high in
// S_COMMIT. Status tells empty, not found and full apart, and the value is
// zero on any failure.
// ----------------------------------------------------------------------------
module array_list_delete_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [aldel_pkg::CMD_W-1:0]          req_cmd,
   input  logic signed [aldel_pkg::DATA_W-1:0]  req_value,
   output logic                                 rsp_strobe,
   output logic signed [aldel_pkg::DATA_W-1:0]  rsp_result_value,
   output logic [aldel_pkg::STATUS_W-1:0]       rsp_status,
   output logic [aldel_pkg::COUNT_W-1:0]        rsp_count
);

   aldel_pkg::ctrl_type ctrl;
   aldel_pkg::stat_type stat;

   // Command sequencing.
   aldel_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_cmd    (req_cmd),
      .stat       (stat),
      .ctrl       (ctrl),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // Entry store and result datapath.
   aldel_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .req_value        (req_value),
      .stat             (stat),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_count        (rsp_count)
   );

endmodule

/* src/aldel_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Array list delete engine controller
// Accepts a command, then in the following cycle decides the store update and
// the result status from the datapath flags and issues the result strobe.
// ----------------------------------------------------------------------------
module aldel_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [aldel_pkg::CMD_W-1:0] req_cmd,
   input  aldel_pkg::stat_type         stat,
   output aldel_pkg::ctrl_type         ctrl,
   output logic                        busy,
   output logic                        rsp_strobe
);

   aldel_pkg::state_type state_ff, state_in;
   aldel_pkg::cmd_type   cmd_ff, cmd_in;
   logic                 strobe_ff, strobe_in;

   // State, command and strobe registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= aldel_pkg::S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      cmd_ff <= cmd_in;
   end

   // Next state and command decode.
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      strobe_in   = 1'b0;
      ctrl.load   = 1'b0;
      ctrl.commit = 1'b0;
      ctrl.op     = aldel_pkg::OP_NONE;
      ctrl.status = aldel_pkg::ST_OK;
      case (state_ff)
         aldel_pkg::S_IDLE: begin
            if (start) begin
               ctrl.load = 1'b1;
               cmd_in    = aldel_pkg::cmd_type'(req_cmd);
               state_in  = aldel_pkg::S_COMMIT;
            end
         end
         aldel_pkg::S_COMMIT: begin
            ctrl.commit = 1'b1;
            strobe_in   = 1'b1;
            state_in    = aldel_pkg::S_IDLE;
            if (cmd_ff == aldel_pkg::CMD_APPEND) begin
               if (stat.full) begin
                  ctrl.status = aldel_pkg::ST_FULL;
               end else begin
                  ctrl.op = aldel_pkg::OP_APPEND;
               end
            end else if (stat.empty) begin
               ctrl.status = aldel_pkg::ST_EMPTY;
            end else begin
               case (cmd_ff)
                  aldel_pkg::CMD_DEL_FIRST: begin
                     ctrl.op = aldel_pkg::OP_DEL_HEAD;
                  end
                  aldel_pkg::CMD_DEL_LAST: begin
                     ctrl.op = aldel_pkg::OP_DEL_LAST;
                  end
                  aldel_pkg::CMD_DEL_VALUE: begin
                     if (stat.found) begin
                        ctrl.op = aldel_pkg::OP_DEL_MATCH;
                     end else begin
                        ctrl.status = aldel_pkg::ST_NOT_FOUND;
                     end
                  end
                  default: begin
                     ctrl.op = aldel_pkg::OP_NONE;
                  end
               endcase
            end
         end
         default: begin
            state_in = aldel_pkg::S_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff == aldel_pkg::S_COMMIT);
   assign rsp_strobe = strobe_ff;

endmodule

/* src/aldel_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Array list delete engine datapath
// Register-file entry store with entry count, a registered match vector from
// the parallel compare, and the gap-closing shift network.
// ----------------------------------------------------------------------------
module aldel_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  aldel_pkg::ctrl_type                   ctrl,
   input  logic signed [aldel_pkg::DATA_W-1:0]   req_value,
   output aldel_pkg::stat_type                   stat,
   output logic signed [aldel_pkg::DATA_W-1:0]   rsp_result_value,
   output logic [aldel_pkg::STATUS_W-1:0]        rsp_status,
   output logic [aldel_pkg::COUNT_W-1:0]         rsp_count
);

   localparam int CAP = aldel_pkg::CAPACITY;
   localparam int CNT_W = aldel_pkg::CNT_W;
   localparam int IDX_W = aldel_pkg::IDX_W;
   localparam int DATA_W = aldel_pkg::DATA_W;
   localparam int COUNT_W = aldel_pkg::COUNT_W;

   logic [DATA_W-1:0]           entries_ff [CAP];
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [CAP-1:0]              match_ff, match_in;
   logic [DATA_W-1:0]           value_ff;
   logic [DATA_W-1:0]           result_ff, result_in;
   logic [aldel_pkg::STATUS_W-1:0] status_ff;
   logic [CNT_W-1:0]            count_out_ff;

   logic [CNT_W-1:0]            last_pos;
   logic [CAP-1:0]              first_hit;
   logic [CAP-1:0]              shift_mask;
   logic [CNT_W+COUNT_W-1:0]    count_wide;

   // Parallel compare of the incoming value against every live entry.
   always_comb begin
      for (int i = 0; i < CAP; i++) begin
         match_in[i] = (entries_ff[i] == req_value) && (CNT_W'(i) < count_ff);
      end
   end

   // Position of the tail entry.
   assign last_pos = count_ff - CNT_W'(1);

   // Entries at and above the first match move down by one.
   always_comb begin
      first_hit = match_ff & (~match_ff + CAP'(1));
      if (ctrl.op == aldel_pkg::OP_DEL_HEAD) begin
         shift_mask = {CAP{1'b1}};
      end else begin
         shift_mask = ~(first_hit - CAP'(1));
      end
   end

   // Result value and new count for the completing command.
   always_comb begin
      result_in = '0;
      count_in  = count_ff;
      case (ctrl.op)
         aldel_pkg::OP_APPEND: begin
            result_in = value_ff;
            count_in  = count_ff + CNT_W'(1);
         end
         aldel_pkg::OP_DEL_HEAD: begin
            result_in = entries_ff[0];
            count_in  = last_pos;
         end
         aldel_pkg::OP_DEL_LAST: begin
            result_in = entries_ff[last_pos[IDX_W-1:0]];
            count_in  = last_pos;
         end
         aldel_pkg::OP_DEL_MATCH: begin
            result_in = value_ff;
            count_in  = last_pos;
         end
         default: begin
            result_in = '0;
         end
      endcase
   end

   // Control registers: entry count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctrl.commit) begin
         count_ff <= count_in;
      end
   end

   // Operand capture and match vector.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         value_ff <= req_value;
         match_ff <= match_in;
      end
   end

   // Entry store updates.
   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         if (ctrl.op == aldel_pkg::OP_APPEND) begin
            entries_ff[count_ff[IDX_W-1:0]] <= value_ff;
         end
         if (ctrl.op == aldel_pkg::OP_DEL_HEAD || ctrl.op == aldel_pkg::OP_DEL_MATCH) begin
            for (int i = 0; i < CAP - 1; i++) begin
               if (shift_mask[i]) begin
                  entries_ff[i] <= entries_ff[i + 1];
               end
            end
         end
      end
   end

   // Result registers, shown for one cycle by the strobe.
   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         result_ff    <= result_in;
         status_ff    <= ctrl.status;
         count_out_ff <= count_in;
      end
   end

   // Flags for the controller.
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CNT_W'(CAP));
   assign stat.found = |match_ff;

   assign count_wide       = {{COUNT_W{1'b0}}, count_out_ff};
   assign rsp_result_value = result_ff;
   assign rsp_status       = status_ff;
   assign rsp_count        = count_wide[COUNT_W-1:0];

endmodule
